// ----- hw/rtl/mclb_pkg.sv -----
// mclb_pkg: types, codes and constants shared by the multi-channel LED blinker
// depends on nothing; imported by every module of the block
`timescale 1ns / 1ps

package mclb_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_BITS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PCT   = 2'd1;

	localparam logic [4:0] DUTY_BITS_RST = 5'd13;
	localparam logic [4:0] DUTY_BITS_MAX = 5'd20;
	localparam logic [6:0] PCT_RST       = 7'd100;
	localparam logic [6:0] PCT_MAX       = 7'd100;

	// on duty = full_scale * pct / 100, divide done as multiply by reciprocal
	localparam int DUTY_W      = 20;
	localparam int PROD_W      = 27;
	localparam int RECIP_W     = 28;
	localparam int RECIP_SHIFT = 34;
	localparam int QUOT_W      = PROD_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_100 = 28'd171798692;

	// opcodes
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_BLINK = 2'd1;
	localparam logic [1:0] OP_SET   = 2'd2;

	// result codes
	localparam logic       KIND_DUTY     = 1'b0;
	localparam logic       KIND_STATUS   = 1'b1;
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_NO_CHANNEL = 2'd1;
	localparam logic [1:0] ST_ALREADY    = 2'd2;

	// channel level codes
	localparam logic [1:0] LVL_UNKNOWN = 2'd0;
	localparam logic [1:0] LVL_OFF     = 2'd1;
	localparam logic [1:0] LVL_ON      = 2'd2;

	// result buffer and command queue sizes
	localparam int MAX_RESULTS = 8;
	localparam int RES_IDX_W   = 3;
	localparam int RES_CNT_W   = 4;
	localparam int Q_DEPTH     = 2;
	localparam int Q_PTR_W     = 1;
	localparam int Q_CNT_W     = 2;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [5:0]         pin;
		logic [15:0]        on_time_ms;
		logic [15:0]        off_time_ms;
		logic signed [15:0] repeat_count;
		logic               level;
		logic [31:0]        now_ms;
	} mclb_cmd_t;

	typedef struct packed {
		logic        kind;
		logic [1:0]  status;
		logic [2:0]  channel;
		logic [5:0]  pin_out;
		logic [19:0] duty;
		logic        blinking_active;
		logic        last;
	} mclb_res_t;

	typedef enum logic [1:0] {
		CLS_TICK,
		CLS_BLINK,
		CLS_SET,
		CLS_NOP
	} mclb_cls_t;

	// classified command as it sits in the queue
	typedef struct packed {
		mclb_cls_t   cls;
		logic [5:0]  pin;
		logic [15:0] on_time_ms;
		logic [15:0] off_time_ms;
		logic [15:0] repeat_count;
		logic        level;
		logic [31:0] now_ms;
	} mclb_job_t;

	// one buffered result before the active flag and last mark are known
	typedef struct packed {
		logic        kind;
		logic [1:0]  status;
		logic [2:0]  channel;
		logic [5:0]  pin_out;
		logic [19:0] duty;
	} mclb_ent_t;

	typedef struct packed {
		logic        free;
		logic [5:0]  pin;
		logic [15:0] on_len;
		logic [15:0] off_len;
		logic [15:0] repeats;
		logic [31:0] phase_start;
		logic        in_off;
		logic        blinking;
		logic [1:0]  level;
	} mclb_chan_t;

	localparam mclb_chan_t CHAN_RST = '{
		free: 1'b1, pin: 6'd0, on_len: 16'd0, off_len: 16'd0, repeats: 16'd0,
		phase_start: 32'd0, in_off: 1'b1, blinking: 1'b0, level: LVL_UNKNOWN
	};

	typedef enum logic [2:0] {
		S_IDLE,
		S_FIND,
		S_APPLY,
		S_WALK,
		S_EMIT
	} mclb_state_t;

	function automatic mclb_cls_t classify(input logic [1:0] opcode);
		mclb_cls_t c;
		case (opcode)
			OP_TICK:  c = CLS_TICK;
			OP_BLINK: c = CLS_BLINK;
			OP_SET:   c = CLS_SET;
			default:  c = CLS_NOP;
		endcase
		return c;
	endfunction

endpackage

// ----- hw/rtl/multi_channel_led_blinker_top.sv -----
// multi_channel_led_blinker_top: LED channel table with set-level, blink and tick commands
// tick: walks the channels one per cycle, then emits the buffered results
// the executor handles one item at a time; the front queues up to two more while it works
// reset: async active-low, all channels free, off phase, duty_bits 13, max 100 percent
`timescale 1ns / 1ps

module multi_channel_led_blinker_top #(
	parameter int CHANNELS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// command side
	input  logic                            start,
	output logic                            busy,
	input  mclb_pkg::mclb_cmd_t             cmd,
	// result side, no back-pressure
	output logic                            res_valid,
	output mclb_pkg::mclb_res_t             res,
	// register writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mclb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mclb_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mclb_pkg::*;

	// queue head between the front and the executor
	logic              q_valid;
	mclb_job_t         job;
	logic              pop;
	logic [DUTY_W-1:0] on_duty;

	// front: takes an item whenever the two-entry queue has room, so busy
	// only rises while the executor is still working on earlier items
	mclb_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.q_valid (q_valid),
		.job     (job),
		.pop     (pop)
	);

	// register file plus the on-duty value, registered through prod_q and on_duty_q after a write
	mclb_duty u_duty (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.on_duty   (on_duty)
	);

	// back: one channel per cycle on a tick; results are buffered until the
	// step is done, since every result carries the final blinking flag
	mclb_exec #(
		.CHANNELS (CHANNELS)
	) u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.job       (job),
		.pop       (pop),
		.on_duty   (on_duty),
		.res_valid (res_valid),
		.res       (res)
	);

	// duty updates are always plain successes
	a_duty_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == KIND_DUTY |-> res.status == ST_OK)
		else $error("duty update with non-ok status");

	// status-only results never carry a duty
	a_status_no_duty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == KIND_STATUS |-> res.duty == '0)
		else $error("status-only result with duty");

	// results of one item leave in consecutive cycles up to the last one
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.last |=> res_valid)
		else $error("gap inside a result burst");

endmodule

// ----- hw/rtl/mclb_front.sv -----
// mclb_front: command intake, opcode classification and a two-entry job queue
// depends on mclb_pkg
`timescale 1ns / 1ps

module mclb_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  mclb_pkg::mclb_cmd_t cmd,
	output logic                q_valid,
	output mclb_pkg::mclb_job_t job,
	input  logic                pop
);
	import mclb_pkg::*;

	mclb_job_t           q_mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]  wr_ptr_q;
	logic [Q_PTR_W-1:0]  rd_ptr_q;
	logic [Q_CNT_W-1:0]  cnt_q;
	logic                accept;
	mclb_job_t           in_job;

	assign busy    = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign accept  = start && !busy;
	assign q_valid = (cnt_q != '0);
	assign job     = q_mem_q[rd_ptr_q];

	always_comb begin
		in_job.cls          = classify(cmd.opcode);
		in_job.pin          = cmd.pin;
		in_job.on_time_ms   = cmd.on_time_ms;
		in_job.off_time_ms  = cmd.off_time_ms;
		in_job.repeat_count = cmd.repeat_count;
		in_job.level        = cmd.level;
		in_job.now_ms       = cmd.now_ms;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({accept, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			q_mem_q[wr_ptr_q] <= in_job;
		end
	end

endmodule

// ----- hw/rtl/mclb_duty.sv -----
// mclb_duty: configuration registers and the registered on-duty computation
// depends on mclb_pkg
`timescale 1ns / 1ps

module mclb_duty (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [mclb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mclb_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic [mclb_pkg::DUTY_W-1:0]     on_duty
);
	import mclb_pkg::*;

	logic [4:0]        duty_bits_q;
	logic [6:0]        pct_q;
	logic [4:0]        bits_c;
	logic [6:0]        pct_c;
	logic [DUTY_W-1:0] full_scale;
	logic [PROD_W-1:0] prod_q;
	logic [QUOT_W-1:0] quot;
	logic [DUTY_W-1:0] on_duty_q;

	assign cfg_ready = 1'b1;
	assign on_duty   = on_duty_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_bits_q <= DUTY_BITS_RST;
			pct_q       <= PCT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DUTY_BITS: duty_bits_q <= cfg_data[4:0];
				REG_MAX_PCT:   pct_q       <= cfg_data[6:0];
				default:       ;
			endcase
		end
	end

	// clamp out-of-range settings
	assign bits_c     = (duty_bits_q > DUTY_BITS_MAX) ? DUTY_BITS_MAX : duty_bits_q;
	assign pct_c      = (pct_q > PCT_MAX) ? PCT_MAX : pct_q;
	assign full_scale = DUTY_W'((21'd1 << bits_c) - 21'd1);
	assign quot       = {{(QUOT_W-PROD_W){1'b0}}, prod_q}
	                  * {{(QUOT_W-RECIP_W){1'b0}}, RECIP_100};

	always_ff @(posedge clk) begin
		prod_q    <= {{(PROD_W-DUTY_W){1'b0}}, full_scale} * {{(PROD_W-7){1'b0}}, pct_c};
		on_duty_q <= DUTY_W'(quot >> RECIP_SHIFT);
	end

endmodule

// ----- hw/rtl/mclb_exec.sv -----
// mclb_exec: channel table, command execution, tick walk and result buffer
// depends on mclb_pkg; fed by mclb_front, duty from mclb_duty
`timescale 1ns / 1ps

module mclb_exec #(
	parameter int CHANNELS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  mclb_pkg::mclb_job_t         job,
	output logic                        pop,
	input  logic [mclb_pkg::DUTY_W-1:0] on_duty,
	output logic                        res_valid,
	output mclb_pkg::mclb_res_t         res
);
	import mclb_pkg::*;

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

	mclb_state_t          state_q, state_d;
	mclb_job_t            job_q;
	mclb_chan_t           chan_q [CHANNELS];
	mclb_ent_t            rbuf_q [MAX_RESULTS];
	logic [CH_W-1:0]      idx_q;
	logic [RES_CNT_W-1:0] n_q;
	logic [RES_IDX_W-1:0] rd_q;
	logic                 res_valid_q;
	mclb_res_t            res_q;

	mclb_chan_t           cur;
	logic                 found;
	logic [CH_W-1:0]      found_idx;
	logic                 active;
	logic                 emit_last;
	logic [31:0]          elapsed;
	logic [15:0]          thr;
	logic                 expired;

	logic                 push;
	mclb_ent_t            push_ent;
	logic                 tab_we;
	mclb_chan_t           tab_ent;

	assign cur       = chan_q[idx_q];
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign emit_last = ({1'b0, rd_q} == (n_q - RES_CNT_W'(1)));
	assign elapsed   = job_q.now_ms - cur.phase_start;
	assign thr       = cur.in_off ? cur.off_len : cur.on_len;
	assign expired   = elapsed > {16'd0, thr};

	// channel search: first channel bound to the pin, else highest free one
	always_comb begin
		logic            free_any, match_any;
		logic [CH_W-1:0] free_idx, match_idx;
		free_any  = 1'b0;
		match_any = 1'b0;
		free_idx  = '0;
		match_idx = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			if (chan_q[i].free) begin
				free_any = 1'b1;
				free_idx = CH_W'(i);
			end else if (!match_any && chan_q[i].pin == job_q.pin) begin
				match_any = 1'b1;
				match_idx = CH_W'(i);
			end
		end
		found     = match_any || free_any;
		found_idx = match_any ? match_idx : free_idx;
	end

	always_comb begin
		active = 1'b0;
		for (int i = 0; i < CHANNELS; i++) begin
			if (!chan_q[i].free && chan_q[i].blinking) begin
				active = 1'b1;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					state_d = (job.cls == CLS_TICK) ? S_WALK : S_FIND;
				end
			end
			S_FIND: begin
				if (job_q.cls == CLS_NOP || !found) begin
					state_d = S_EMIT;
				end else begin
					state_d = S_APPLY;
				end
			end
			S_APPLY: state_d = S_EMIT;
			S_WALK: begin
				if (idx_q == LAST_CH) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (emit_last) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// per-state actions
	always_comb begin
		logic [1:0] want;
		logic       changed;
		logic [19:0] wduty;
		pop      = 1'b0;
		push     = 1'b0;
		push_ent = '0;
		tab_we   = 1'b0;
		tab_ent  = cur;
		want     = LVL_OFF;
		changed  = 1'b0;
		wduty    = '0;
		case (state_q)
			S_IDLE: pop = q_valid;
			S_FIND: begin
				if (job_q.cls == CLS_NOP) begin
					push            = 1'b1;
					push_ent.kind   = KIND_STATUS;
					push_ent.status = ST_OK;
				end else if (!found) begin
					push            = 1'b1;
					push_ent.kind   = KIND_STATUS;
					push_ent.status = ST_NO_CHANNEL;
				end
			end
			S_APPLY: begin
				push             = 1'b1;
				push_ent.channel = 3'(idx_q);
				if (job_q.cls == CLS_BLINK) begin
					tab_we              = 1'b1;
					tab_ent.free        = 1'b0;
					tab_ent.pin         = job_q.pin;
					tab_ent.phase_start = job_q.now_ms;
					tab_ent.on_len      = job_q.on_time_ms;
					tab_ent.off_len     = job_q.off_time_ms;
					tab_ent.repeats     = job_q.repeat_count;
					tab_ent.blinking    = 1'b1;
					tab_ent.in_off      = 1'b1;
					tab_ent.level       = LVL_OFF;
					push_ent.kind       = KIND_DUTY;
					push_ent.status     = ST_OK;
					push_ent.pin_out    = job_q.pin;
				end else begin
					want = job_q.level ? LVL_ON : LVL_OFF;
					if (cur.level == want) begin
						// already there: report only, blinking untouched
						push_ent.kind    = KIND_STATUS;
						push_ent.status  = ST_ALREADY;
						push_ent.pin_out = cur.pin;
					end else begin
						tab_we              = 1'b1;
						tab_ent.free        = 1'b0;
						tab_ent.pin         = job_q.pin;
						tab_ent.phase_start = job_q.now_ms;
						tab_ent.on_len      = '0;
						tab_ent.off_len     = '0;
						tab_ent.repeats     = '0;
						tab_ent.blinking    = 1'b0;
						tab_ent.level       = want;
						push_ent.kind       = KIND_DUTY;
						push_ent.status     = ST_OK;
						push_ent.pin_out    = job_q.pin;
						push_ent.duty       = job_q.level ? on_duty : '0;
					end
				end
			end
			S_WALK: begin
				if (!cur.free && cur.blinking) begin
					tab_we = 1'b1;
					if (cur.repeats == '0) begin
						// blink used up: switch off and stop
						tab_ent.blinking = 1'b0;
						tab_ent.level    = LVL_OFF;
						changed          = (cur.level != LVL_OFF);
					end else if (expired) begin
						if (!cur.repeats[15]) begin
							tab_ent.repeats = cur.repeats - 16'd1;
						end
						tab_ent.in_off      = !cur.in_off;
						want                = cur.in_off ? LVL_ON : LVL_OFF;
						tab_ent.level       = want;
						tab_ent.phase_start = job_q.now_ms;
						changed             = (cur.level != want);
						wduty               = cur.in_off ? on_duty : '0;
					end
				end
				if (changed && n_q < RES_CNT_W'(MAX_RESULTS)) begin
					push             = 1'b1;
					push_ent.kind    = KIND_DUTY;
					push_ent.status  = ST_OK;
					push_ent.channel = 3'(idx_q);
					push_ent.pin_out = cur.pin;
					push_ent.duty    = wduty;
				end else if (idx_q == LAST_CH && n_q == '0) begin
					// quiet tick still answers once
					push            = 1'b1;
					push_ent.kind   = KIND_STATUS;
					push_ent.status = ST_OK;
				end
			end
			S_EMIT: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			n_q         <= '0;
			rd_q        <= '0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				chan_q[i] <= CHAN_RST;
			end
		end else begin
			state_q     <= state_d;
			res_valid_q <= (state_q == S_EMIT);
			if (pop) begin
				idx_q <= '0;
				n_q   <= '0;
				rd_q  <= '0;
			end
			if (state_q == S_FIND && found) begin
				idx_q <= found_idx;
			end
			if (state_q == S_WALK) begin
				idx_q <= idx_q + 1'b1;
			end
			if (push) begin
				n_q <= n_q + 1'b1;
			end
			if (state_q == S_EMIT) begin
				rd_q <= rd_q + 1'b1;
			end
			if (tab_we) begin
				chan_q[idx_q] <= tab_ent;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= job;
		end
		if (push) begin
			rbuf_q[n_q[RES_IDX_W-1:0]] <= push_ent;
		end
		if (state_q == S_EMIT) begin
			res_q.kind            <= rbuf_q[rd_q].kind;
			res_q.status          <= rbuf_q[rd_q].status;
			res_q.channel         <= rbuf_q[rd_q].channel;
			res_q.pin_out         <= rbuf_q[rd_q].pin_out;
			res_q.duty            <= rbuf_q[rd_q].duty;
			res_q.blinking_active <= active;
			res_q.last            <= emit_last;
		end
	end

endmodule
